/* rtl/mse_pkg.sv */
// Package for the merge sort engine: sizes, widths and the controller state type.
// Used by rtl/merge_sort_engine_top.sv; depends on nothing.
package mse_pkg;
  localparam int MaxElements = 64;
  localparam int ValueWidth  = 32;
  localparam int AddrWidth   = $clog2(MaxElements);
  localparam int CountWidth  = $clog2(MaxElements + 1);
  localparam int TotalWidth  = 20;
  localparam logic [TotalWidth-1:0] TotalMax = '1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PASS_INIT,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_MERGE_RD,
    ST_MERGE_WR,
    ST_NEXT_RUN,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_HOLD
  } state_t;
endpackage

/* rtl/merge_sort_engine_top.sv */
// Merge sort engine top level: loads a list, sorts it with a stable merge, emits it.
// Depends on rtl/mse_pkg.sv.
// After the beat marked last, the list is copied and merged range by range along the split
//   tree; each result is then read, registered and held on the output until it is taken.
//   Load accepts one beat a cycle.
// Throughput: one list at a time.
// Merging follows the post-order walk of the top-down split with ceil(n/2) left halves,
//   kept on a small range stack, giving the same comparisons, writes and order.
// Reset: synchronous, clears the controller, counts and flags; memories are not cleared.
module merge_sort_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // sorted_value[31:0], compare_total[51:32], move_total[71:52]
  output logic        m_tlast,
  output logic        m_tuser    // overflow
);
  localparam int AW = mse_pkg::AddrWidth;
  localparam int CW = mse_pkg::CountWidth;
  localparam int VW = mse_pkg::ValueWidth;
  localparam int TW = mse_pkg::TotalWidth;

  mse_pkg::state_t state, state_next;

  logic [VW-1:0] elem_mem [mse_pkg::MaxElements];
  logic [VW-1:0] scr_mem  [mse_pkg::MaxElements];

  logic [CW-1:0] count;
  logic [TW-1:0] cmp_total, mov_total;
  logic          dropped;

  // Pass state: the runs of one level of the split tree. A range of length n splits
  // into ceil(n/2) and floor(n/2); at depth d all ranges have one of two lengths.
  // Instead of the tree, each pass recomputes segment bounds by a recursive walk held
  // in a small range table; simplest exact form: explicit stack of (lo,hi,phase).
  // Each level of the tree takes two entries, so 64 elements need up to 13.
  logic [CW-1:0] stk_lo [16];
  logic [CW-1:0] stk_hi [16];
  logic          stk_ph [16];
  logic [3:0]    sp;

  logic [CW-1:0] lo, mid, hi, i, j, k, t;
  logic [VW-1:0] rd_elem, rd_a, rd_b;
  logic [CW-1:0] emit_idx;
  logic [VW-1:0] out_val;
  logic          out_last;

  logic [CW-1:0] top_lo, top_hi, top_mid;
  assign top_lo  = stk_lo[sp];
  assign top_hi  = stk_hi[sp];
  assign top_mid = top_lo + CW'((top_hi - top_lo) >> 1);

  logic i_ok, j_ok, take_i;
  assign i_ok   = (i <= mid);
  assign j_ok   = (j <= hi);
  assign take_i = i_ok && (!j_ok || ($signed(rd_a) <= $signed(rd_b)));

  assign s_tready = (state == mse_pkg::ST_LOAD);
  assign m_tvalid = (state == mse_pkg::ST_EMIT_HOLD);
  assign m_tdata  = {mov_total, cmp_total, out_val};
  assign m_tlast  = out_last;
  assign m_tuser  = dropped;

  always_comb begin
    state_next = state;
    unique case (state)
      mse_pkg::ST_LOAD:
        if (s_tvalid && s_tlast) state_next = mse_pkg::ST_PASS_INIT;
      mse_pkg::ST_PASS_INIT: state_next = mse_pkg::ST_NEXT_RUN;
      mse_pkg::ST_NEXT_RUN: begin
        if (sp == 4'hF) state_next = mse_pkg::ST_EMIT_RD;
        else if (stk_ph[sp] && top_lo < top_hi) state_next = mse_pkg::ST_COPY_RD;
      end
      mse_pkg::ST_COPY_RD: state_next = mse_pkg::ST_COPY_WR;
      mse_pkg::ST_COPY_WR:
        state_next = (t == hi) ? mse_pkg::ST_MERGE_RD : mse_pkg::ST_COPY_RD;
      mse_pkg::ST_MERGE_RD: state_next = mse_pkg::ST_MERGE_WR;
      mse_pkg::ST_MERGE_WR:
        state_next = (k == hi) ? mse_pkg::ST_NEXT_RUN : mse_pkg::ST_MERGE_RD;
      mse_pkg::ST_EMIT_RD: state_next = mse_pkg::ST_EMIT_WAIT;
      mse_pkg::ST_EMIT_WAIT: state_next = mse_pkg::ST_EMIT_HOLD;
      mse_pkg::ST_EMIT_HOLD:
        if (m_tready) state_next = out_last ? mse_pkg::ST_LOAD : mse_pkg::ST_EMIT_RD;
      default: state_next = mse_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mse_pkg::ST_LOAD;
    else     state <= state_next;
  end

  // Memories: the element store has one write and one read port, the scratch store
  // one write and two read ports modeled as a duplicated copy would be; reads registered.
  logic [AW-1:0] e_rd_addr;
  assign e_rd_addr = (state == mse_pkg::ST_EMIT_RD) ? emit_idx[AW-1:0] : t[AW-1:0];

  always_ff @(posedge clk) begin
    rd_elem <= elem_mem[e_rd_addr];
    rd_a    <= scr_mem[i[AW-1:0]];
    rd_b    <= scr_mem[j[AW-1:0]];
    if (state == mse_pkg::ST_LOAD && s_tvalid && s_tready && count < CW'(mse_pkg::MaxElements))
      elem_mem[count[AW-1:0]] <= s_tdata[VW-1:0];
    if (state == mse_pkg::ST_COPY_WR)
      scr_mem[t[AW-1:0]] <= rd_elem;
    if (state == mse_pkg::ST_MERGE_WR)
      elem_mem[k[AW-1:0]] <= take_i ? rd_a : rd_b;
    if (state == mse_pkg::ST_EMIT_WAIT) begin
      out_val  <= rd_elem;
      out_last <= (emit_idx + CW'(1) == count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cmp_total <= '0;
      mov_total <= '0;
      dropped   <= 1'b0;
      sp        <= '0;
      emit_idx  <= '0;
    end else begin
      unique case (state)
        mse_pkg::ST_LOAD:
          if (s_tvalid) begin
            if (count < CW'(mse_pkg::MaxElements)) count <= count + CW'(1);
            else dropped <= 1'b1;
          end
        mse_pkg::ST_PASS_INIT: begin
          // Walk the split tree in post order: phase 0 pushes children, phase 1 merges.
          sp        <= '0;
          stk_lo[0] <= '0;
          stk_hi[0] <= count - CW'(1);
          stk_ph[0] <= 1'b0;
          emit_idx  <= '0;
        end
        mse_pkg::ST_NEXT_RUN: begin
          if (sp != 4'hF) begin
            if (top_lo >= top_hi) begin
              sp <= sp - 4'd1;
            end else if (!stk_ph[sp]) begin
              stk_ph[sp]         <= 1'b1;
              stk_lo[sp + 4'd1]  <= top_mid + CW'(1);
              stk_hi[sp + 4'd1]  <= top_hi;
              stk_ph[sp + 4'd1]  <= 1'b0;
              stk_lo[sp + 4'd2]  <= top_lo;
              stk_hi[sp + 4'd2]  <= top_mid;
              stk_ph[sp + 4'd2]  <= 1'b0;
              sp <= sp + 4'd2;
            end else begin
              lo  <= top_lo;
              mid <= top_mid;
              hi  <= top_hi;
              t   <= top_lo;
              sp  <= sp - 4'd1;
            end
          end
        end
        mse_pkg::ST_COPY_WR: begin
          if (t == hi) begin
            i <= lo;
            j <= mid + CW'(1);
            k <= lo;
          end else begin
            t <= t + CW'(1);
          end
        end
        mse_pkg::ST_MERGE_WR: begin
          if (i_ok && j_ok && cmp_total != mse_pkg::TotalMax) cmp_total <= cmp_total + TW'(1);
          if (mov_total != mse_pkg::TotalMax) mov_total <= mov_total + TW'(1);
          i <= take_i ? i + CW'(1) : i;
          j <= take_i ? j : j + CW'(1);
          k <= k + CW'(1);
        end
        mse_pkg::ST_EMIT_HOLD:
          if (m_tready) begin
            emit_idx <= emit_idx + CW'(1);
            if (out_last) begin
              count     <= '0;
              cmp_total <= '0;
              mov_total <= '0;
              dropped   <= 1'b0;
            end
          end
        default: ;
      endcase
    end
  end
endmodule
